// ----- design/tgrf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tgrf_pkg;

  localparam int GRID_SIDE_DEF = 64;
  localparam int COORD_W       = 8;
  localparam int CODE_W        = 9;
  localparam int CMD_W         = 2;

  // all ones is the empty tile (-1)
  localparam logic [CODE_W-1:0] EMPTY_CODE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET     = 2'd0,
    CMD_OUTLINE = 2'd1,
    CMD_FILL    = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLIP,
    ST_SCAN,
    ST_READ,
    ST_RESP
  } state_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x_lo;
    coord_t x_hi;
    coord_t y_lo;
    coord_t y_hi;
  } rect_t;

  typedef struct packed {
    logic load;
    logic step;
  } walk_ctl_t;

  typedef struct packed {
    logic span_empty;
    logic span_last;
  } walk_sts_t;

endpackage

`default_nettype wire

// ----- design/tgrf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tgrf_ram #(
  parameter int WIDTH = tgrf_pkg::CODE_W,
  parameter int DEPTH = tgrf_pkg::GRID_SIDE_DEF * tgrf_pkg::GRID_SIDE_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/tgrf_walk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tgrf_walk #(
  parameter int GRID_SIDE = tgrf_pkg::GRID_SIDE_DEF
) (
  input  logic                         clk,
  input  tgrf_pkg::rect_t              rect,
  input  tgrf_pkg::walk_ctl_t          ctl,
  output tgrf_pkg::walk_sts_t          sts,
  output logic [$clog2(GRID_SIDE)-1:0] cur_x,
  output logic [$clog2(GRID_SIDE)-1:0] cur_y
);

  import tgrf_pkg::*;

  localparam int     CW    = $clog2(GRID_SIDE);
  localparam coord_t MAX_C = COORD_W'(GRID_SIDE - 1);

  coord_t xl, xh, yl, yh;
  coord_t xs, xe, ys, ye;
  logic [CW-1:0] end_x, end_y, start_y;

  assign xl = rect.x_lo;
  assign xh = rect.x_hi;
  assign yl = rect.y_lo;
  assign yh = rect.y_hi;

  // clip the span to the grid
  assign xs = (xl < 0) ? '0 : xl;
  assign ys = (yl < 0) ? '0 : yl;
  assign xe = (xh > MAX_C) ? MAX_C : xh;
  assign ye = (yh > MAX_C) ? MAX_C : yh;

  assign sts.span_empty = (xs > xe) || (ys > ye);
  assign sts.span_last  = (cur_x == end_x) && (cur_y == end_y);

  // column-major scan, row runs fastest
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur_x   <= xs[CW-1:0];
      cur_y   <= ys[CW-1:0];
      start_y <= ys[CW-1:0];
      end_x   <= xe[CW-1:0];
      end_y   <= ye[CW-1:0];
    end else if (ctl.step) begin
      if (cur_y == end_y) begin
        cur_x <= cur_x + 1'b1;
        cur_y <= start_y;
      end else begin
        cur_y <= cur_y + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/tgrf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tgrf_ctrl #(
  parameter int GRID_SIDE = tgrf_pkg::GRID_SIDE_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  output logic                                      busy,
  input  logic [tgrf_pkg::CMD_W-1:0]                command,
  input  logic signed [tgrf_pkg::COORD_W-1:0]       x_first,
  input  logic signed [tgrf_pkg::COORD_W-1:0]       y_first,
  input  logic signed [tgrf_pkg::COORD_W-1:0]       x_last,
  input  logic signed [tgrf_pkg::COORD_W-1:0]       y_last,
  input  logic signed [tgrf_pkg::CODE_W-1:0]        tile_code,
  output logic signed [tgrf_pkg::CODE_W-1:0]        read_code,
  output logic                                      is_read,
  output logic                                      done,
  output tgrf_pkg::rect_t                           rect,
  output tgrf_pkg::walk_ctl_t                       wctl,
  input  tgrf_pkg::walk_sts_t                       wsts,
  input  logic [$clog2(GRID_SIDE)-1:0]              cur_x,
  input  logic [$clog2(GRID_SIDE)-1:0]              cur_y,
  output logic                                      we,
  output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]    waddr,
  output logic [tgrf_pkg::CODE_W-1:0]               wdata,
  output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]    raddr,
  input  logic [tgrf_pkg::CODE_W-1:0]               rdata
);

  import tgrf_pkg::*;

  localparam int     CW    = $clog2(GRID_SIDE);
  localparam int     DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int     AW    = $clog2(DEPTH);
  localparam coord_t MAX_C = COORD_W'(GRID_SIDE - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] cx,
                                              input logic [CW-1:0] cy);
    cell_addr = AW'(cx) * AW'(GRID_SIDE) + AW'(cy);
  endfunction

  state_t state, state_next;
  logic [AW-1:0] clr_addr;
  logic          clr_last;

  cmd_t              cmd_q;
  coord_t            x0_q, y0_q, x1_q, y1_q;
  logic [CODE_W-1:0] code_q;
  logic              on_grid_q;
  logic [1:0]        side_q, side_next;

  logic              accept, on_grid_in, rect_last;
  logic              done_next, is_read_next;
  logic [CODE_W-1:0] read_code_next;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && (state == ST_IDLE);
  assign clr_last   = (clr_addr == AW'(DEPTH - 1));
  assign on_grid_in = (x_first >= 0) && (x_first <= MAX_C) &&
                      (y_first >= 0) && (y_first <= MAX_C);
  assign raddr      = cell_addr(x0_q[CW-1:0], y0_q[CW-1:0]);

  // span for the current side: one span for set and fill, four for an outline
  always_comb begin
    rect_last = (cmd_q != CMD_OUTLINE) || (side_q == 2'd3);
    unique case (cmd_q)
      CMD_FILL:    rect = '{x_lo: x0_q, x_hi: x1_q, y_lo: y0_q, y_hi: y1_q};
      CMD_OUTLINE: begin
        unique case (side_q)
          2'd0:    rect = '{x_lo: x0_q, x_hi: x1_q, y_lo: y0_q, y_hi: y0_q};
          2'd1:    rect = '{x_lo: x0_q, x_hi: x1_q, y_lo: y1_q, y_hi: y1_q};
          2'd2:    rect = '{x_lo: x0_q, x_hi: x0_q, y_lo: y0_q, y_hi: y1_q};
          default: rect = '{x_lo: x1_q, x_hi: x1_q, y_lo: y0_q, y_hi: y1_q};
        endcase
      end
      default:     rect = '{x_lo: x0_q, x_hi: x0_q, y_lo: y0_q, y_hi: y0_q};
    endcase
  end

  always_comb begin
    state_next     = state;
    side_next      = side_q;
    wctl           = '0;
    we             = 1'b0;
    waddr          = cell_addr(cur_x, cur_y);
    wdata          = code_q;
    done_next      = 1'b0;
    is_read_next   = 1'b0;
    read_code_next = '0;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = EMPTY_CODE;
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          side_next  = 2'd0;
          state_next = (command == CMD_READ) ? ST_READ : ST_CLIP;
        end
      end
      ST_CLIP: begin
        wctl.load = 1'b1;
        if (!wsts.span_empty) begin
          state_next = ST_SCAN;
        end else if (rect_last) begin
          state_next = ST_RESP;
        end else begin
          side_next = side_q + 1'b1;
        end
      end
      ST_SCAN: begin
        we        = 1'b1;
        wctl.step = 1'b1;
        if (wsts.span_last) begin
          if (rect_last) begin
            state_next = ST_RESP;
          end else begin
            side_next  = side_q + 1'b1;
            state_next = ST_CLIP;
          end
        end
      end
      ST_READ: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        done_next  = 1'b1;
        state_next = ST_IDLE;
        if (cmd_q == CMD_READ) begin
          is_read_next   = 1'b1;
          read_code_next = on_grid_q ? rdata : EMPTY_CODE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      side_q   <= 2'd0;
      done     <= 1'b0;
    end else begin
      state  <= state_next;
      side_q <= side_next;
      done   <= done_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    read_code <= read_code_next;
    is_read   <= is_read_next;
    if (accept) begin
      cmd_q     <= cmd_t'(command);
      x0_q      <= x_first;
      y0_q      <= y_first;
      x1_q      <= x_last;
      y1_q      <= y_last;
      code_q    <= tile_code;
      on_grid_q <= on_grid_in;
    end
  end

endmodule

`default_nettype wire

// ----- design/tile_grid_rectangle_fill.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              ports
// command   in         start high, busy low   command x_first y_first x_last y_last tile_code
// result    out        done, one cycle        read_code is_read
//
// one command at a time, one grid cell written per cycle by the scan counter
// read: the RAM is read in ST_READ and the result strobe follows from ST_RESP
// set: one cell, none off the grid; fill: clipped cells; outline: edge cells (corners twice)
// after reset the grid is swept to empty, with busy high
// a new command is taken in the cycle the result strobe is shown

module tile_grid_rectangle_fill #(
  parameter int GRID_SIDE = tgrf_pkg::GRID_SIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [tgrf_pkg::CMD_W-1:0]          command,
  input  logic signed [tgrf_pkg::COORD_W-1:0] x_first,
  input  logic signed [tgrf_pkg::COORD_W-1:0] y_first,
  input  logic signed [tgrf_pkg::COORD_W-1:0] x_last,
  input  logic signed [tgrf_pkg::COORD_W-1:0] y_last,
  input  logic signed [tgrf_pkg::CODE_W-1:0]  tile_code,
  output logic signed [tgrf_pkg::CODE_W-1:0]  read_code,
  output logic                                is_read,
  output logic                                done
);

  import tgrf_pkg::*;

  localparam int CW    = $clog2(GRID_SIDE);
  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);

  rect_t             rect;
  walk_ctl_t         wctl;
  walk_sts_t         wsts;
  logic [CW-1:0]     cur_x, cur_y;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [CODE_W-1:0] wdata, rdata;

  tgrf_ctrl #(
    .GRID_SIDE (GRID_SIDE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .x_first   (x_first),
    .y_first   (y_first),
    .x_last    (x_last),
    .y_last    (y_last),
    .tile_code (tile_code),
    .read_code (read_code),
    .is_read   (is_read),
    .done      (done),
    .rect      (rect),
    .wctl      (wctl),
    .wsts      (wsts),
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  tgrf_walk #(
    .GRID_SIDE (GRID_SIDE)
  ) u_walk (
    .clk   (clk),
    .rect  (rect),
    .ctl   (wctl),
    .sts   (wsts),
    .cur_x (cur_x),
    .cur_y (cur_y)
  );

  tgrf_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ----- design/tgrf_check.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tgrf_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic [tgrf_pkg::CMD_W-1:0]         command,
  input logic signed [tgrf_pkg::CODE_W-1:0] read_code,
  input logic                               is_read,
  input logic                               done
);

  import tgrf_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after command accepted");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !is_read) |-> (read_code == '0))
    else $error("write result carries nonzero read_code");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_READ) |-> ##3 (done && is_read))
    else $error("read result not on time");

endmodule

bind tile_grid_rectangle_fill tgrf_check u_tgrf_check (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .command   (command),
  .read_code (read_code),
  .is_read   (is_read),
  .done      (done)
);

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import tgrf_pkg::*;

  localparam int SIDE       = GRID_SIDE_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int RAND_WORDS = 116;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              rd;
  } tile_reply_t;

  // grid model plus the queue of replies still owed by the block
  class grid_scoreboard;
    logic [CODE_W-1:0] cells [];
    tile_reply_t       replies [$];
    int                errors;

    function new();
      cells = new[SIDE * SIDE];
      foreach (cells[k]) cells[k] = EMPTY_CODE;
      errors = 0;
    endfunction

    function void put_cell(int x, int y, logic [CODE_W-1:0] code);
      if (x >= 0 && x < SIDE && y >= 0 && y < SIDE) cells[x * SIDE + y] = code;
    endfunction

    function logic [CODE_W-1:0] get_cell(int x, int y);
      if (x >= 0 && x < SIDE && y >= 0 && y < SIDE) return cells[x * SIDE + y];
      return EMPTY_CODE;
    endfunction

    function void note_command(cmd_t cmd, coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                               logic [CODE_W-1:0] code);
      int xa, ya, xb, yb, i, j;
      tile_reply_t r;
      xa = x0;
      ya = y0;
      xb = x1;
      yb = y1;
      r.code = '0;
      r.rd = 1'b0;
      case (cmd)
        CMD_SET: put_cell(xa, ya, code);
        CMD_OUTLINE: begin
          for (i = xa; i <= xb; i++) put_cell(i, ya, code);
          for (i = xa; i <= xb; i++) put_cell(i, yb, code);
          for (i = ya; i <= yb; i++) put_cell(xa, i, code);
          for (i = ya; i <= yb; i++) put_cell(xb, i, code);
        end
        CMD_FILL: begin
          for (i = xa; i <= xb; i++)
            for (j = ya; j <= yb; j++) put_cell(i, j, code);
        end
        default: begin
          r.code = get_cell(xa, ya);
          r.rd = 1'b1;
        end
      endcase
      replies = {replies, r};
    endfunction

    function void check_result(logic [CODE_W-1:0] code, logic rd);
      tile_reply_t want;
      if (replies.size() == 0) begin
        $display("%0t: unexpected result, read_code %0d is_read %0b", $time,
                 $signed(code), rd);
        errors++;
        return;
      end
      want = replies.pop_front();
      if (rd !== want.rd) begin
        $display("%0t: is_read mismatch, expected %0b, actual %0b", $time, want.rd, rd);
        errors++;
      end
      if (code !== want.code) begin
        $display("%0t: read_code mismatch, expected %0d, actual %0d", $time,
                 $signed(want.code), $signed(code));
        errors++;
      end
    endfunction

    function int pending();
      return replies.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  command;
  coord_t            x_first;
  coord_t            y_first;
  coord_t            x_last;
  coord_t            y_last;
  logic signed [CODE_W-1:0] tile_code;
  logic signed [CODE_W-1:0] read_code;
  logic              is_read;
  logic              done;

  grid_scoreboard sb;
  int             idle_cycles;

  tile_grid_rectangle_fill uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .x_first   (x_first),
    .y_first   (y_first),
    .x_last    (x_last),
    .y_last    (y_last),
    .tile_code (tile_code),
    .read_code (read_code),
    .is_read   (is_read),
    .done      (done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(read_code, is_read);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // called at a rising edge; returns at the edge that takes the word
  task automatic issue_command(int gap, cmd_t cmd, coord_t x0, coord_t y0, coord_t x1,
                               coord_t y1, logic [CODE_W-1:0] code);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command   <= cmd;
    x_first   <= x0;
    y_first   <= y0;
    x_last    <= x1;
    y_last    <= y1;
    tile_code <= code;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_command(cmd, x0, y0, x1, y1, code);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly on or just off the grid, now and then anywhere in range
  function automatic coord_t pick_coord();
    if ($urandom_range(0, 9) == 0) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 71)) - 4);
  endfunction

  initial begin
    int     n, gap, r, span;
    cmd_t   cmd;
    coord_t x0, y0, x1, y1;
    logic [CODE_W-1:0] code;

    sb = new();
    idle_cycles = 0;
    rst       = 1'b1;
    start     = 1'b0;
    command   = CMD_SET;
    x_first   = '0;
    y_first   = '0;
    x_last    = '0;
    y_last    = '0;
    tile_code = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // corners, off-grid cells, reversed rectangles, full-grid passes
    issue_command(0, CMD_READ, 0, 0, 0, 0, 0);
    issue_command(0, CMD_SET, 0, 0, 127, -128, 0);
    issue_command(1, CMD_READ, 0, 0, -1, -1, 9'h155);
    issue_command(0, CMD_SET, 63, 63, 0, 0, 255);
    issue_command(0, CMD_READ, 63, 63, 0, 0, 0);
    issue_command(2, CMD_SET, -1, 5, 0, 0, 7);
    issue_command(0, CMD_READ, -1, 5, 0, 0, 0);
    issue_command(0, CMD_READ, 64, 5, 0, 0, 0);
    issue_command(0, CMD_SET, 127, -128, 0, 0, 3);
    issue_command(0, CMD_READ, -128, 127, 0, 0, 0);
    issue_command(3, CMD_FILL, 10, 10, 5, 20, 9);
    issue_command(0, CMD_READ, 7, 15, 0, 0, 0);
    issue_command(0, CMD_FILL, 2, 3, 5, 6, 100);
    issue_command(0, CMD_READ, 4, 5, 0, 0, 0);
    issue_command(0, CMD_OUTLINE, 20, 30, 25, 28, 50);
    issue_command(0, CMD_READ, 22, 28, 0, 0, 0);
    issue_command(1, CMD_OUTLINE, 40, 10, 35, 14, 60);
    issue_command(0, CMD_READ, 35, 12, 0, 0, 0);
    issue_command(0, CMD_OUTLINE, -5, 2, 70, 61, 1);
    issue_command(0, CMD_READ, 30, 2, 0, 0, 0);
    issue_command(5, CMD_FILL, -128, -128, 127, 127, EMPTY_CODE);
    issue_command(0, CMD_READ, 4, 5, 0, 0, 0);
    issue_command(0, CMD_FILL, 0, 0, 63, 63, 9'h0AA);
    issue_command(0, CMD_READ, 63, 0, 0, 0, 0);

    for (n = 0; n < RAND_WORDS; n++) begin
      gap = ((n / 20) % 3 == 1) ? 0 : pick_gap();
      r = $urandom_range(0, 99);
      code = CODE_W'($urandom);
      x0 = pick_coord();
      y0 = pick_coord();
      x1 = coord_t'($urandom);
      y1 = coord_t'($urandom);
      if (r < 25) begin
        cmd = CMD_SET;
      end else if (r < 65) begin
        cmd = (r < 45) ? CMD_OUTLINE : CMD_FILL;
        if ($urandom_range(0, 29) == 0) begin
          x0 = coord_t'(-int'($urandom_range(0, 30)));
          y0 = coord_t'(-int'($urandom_range(0, 30)));
          x1 = coord_t'(63 + int'($urandom_range(0, 30)));
          y1 = coord_t'(63 + int'($urandom_range(0, 30)));
        end else begin
          span = ($urandom_range(0, 6) == 0) ? -int'($urandom_range(1, 5))
                                             : int'($urandom_range(0, 10));
          x1 = coord_t'(int'(x0) + span);
          span = ($urandom_range(0, 6) == 0) ? -int'($urandom_range(1, 5))
                                             : int'($urandom_range(0, 10));
          y1 = coord_t'(int'(y0) + span);
        end
      end else begin
        cmd = CMD_READ;
      end
      issue_command(gap, cmd, x0, y0, x1, y1, code);
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
